>>> sv/apv_pkg.sv
// ----------------------------------------------------------------------------
// apv_pkg: shared types and constants of the pitot airspeed unit
// Widths of the divider and square root datapaths, register indexes, reset
// values and the fixed scale factors of the pressure and velocity math.
// ----------------------------------------------------------------------------
package apv_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [1:0] CSR_SUPPLY_MV    = 2'd1;
   localparam logic [1:0] CSR_DENSITY      = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int COUNT_W   = 9;
   localparam int SUPPLY_W  = 13;
   localparam int DENSITY_W = 16;

   localparam logic [COUNT_W-1:0]   SAMPLE_COUNT_RESET = 9'd16;
   localparam logic [SUPPLY_W-1:0]  SUPPLY_MV_RESET    = 13'd5000;
   localparam logic [DENSITY_W-1:0] DENSITY_RESET      = 16'd1200;

   // result fields
   localparam int PD_W  = 13;
   localparam int VEL_W = 20;
   localparam int RSP_W = 40;
   localparam int PD_MAX = 4095;
   localparam int PD_MIN = -4096;
   localparam logic [VEL_W-1:0] VEL_MAX = 20'h7FFFF;

   // converter full scale and velocity scaling: 65536 * 1000 * |dp|
   localparam int ADC_FULL_SCALE = 1023;
   localparam int MAG_W          = 13;
   localparam int VEL_SCALE      = 1000;
   localparam int MAG_SCALED_W   = 23;
   localparam int VEL_SHIFT      = 16;

   // shared divider
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // square root
   localparam int SQ_RAD_W  = 40;
   localparam int SQ_ROOT_W = SQ_RAD_W / 2;
   localparam int SQ_REM_W  = SQ_ROOT_W + 2;
   localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [SQ_RAD_W-1:0] radicand;
   } sq_req_type;

   typedef struct packed {
      logic                 done;
      logic [SQ_ROOT_W-1:0] root;
   } sq_rsp_type;

endpackage

>>> sv/apv_divider.sv
// ----------------------------------------------------------------------------
// apv_divider: restoring divider, one quotient bit per cycle
// Shared by the average, millivolt scaling and velocity divisions.
// ----------------------------------------------------------------------------
module apv_divider
   import apv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      shifted  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff     = shifted - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIV_NUM_W);
         quo_in   = div_req.num;
         rem_in   = '0;
         den_in   = div_req.den;
      end else if (busy_ff) begin
         // keep the partial remainder when the trial subtract goes negative
         if (!diff[DIV_DEN_W]) begin
            rem_in = diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> sv/apv_isqrt.sv
// ----------------------------------------------------------------------------
// apv_isqrt: integer square root, one root bit per cycle
// Restoring digit-by-digit method over bit pairs of the radicand.
// ----------------------------------------------------------------------------
module apv_isqrt
   import apv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  sq_req_type sq_req,
   output sq_rsp_type sq_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SQ_CNT_W-1:0]  count_ff, count_in;
   logic [SQ_RAD_W-1:0]  rad_ff, rad_in;
   logic [SQ_REM_W-1:0]  rem_ff, rem_in;
   logic [SQ_ROOT_W-1:0] root_ff, root_in;
   logic [SQ_REM_W+1:0]  shifted;
   logic [SQ_REM_W+1:0]  trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      shifted  = {rem_ff, rad_ff[SQ_RAD_W-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      if (sq_req.start) begin
         busy_in  = 1'b1;
         count_in = SQ_CNT_W'(SQ_ROOT_W);
         rad_in   = sq_req.radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = SQ_REM_W'(shifted - trial);
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = SQ_REM_W'(shifted);
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == SQ_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = root_ff;

endmodule

>>> sv/averaged_pitot_pressure_velocity_unit.sv
// ----------------------------------------------------------------------------
// averaged_pitot_pressure_velocity_unit: windowed pitot airspeed
// Averages converter samples and turns the average into pressure and velocity.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one converter sample per item. Samples inside a window are
//   taken in one cycle each and produce nothing. The sample that closes the
//   window (sample_count samples) starts the result math and req_tready drops
//   until the result sits in the output register.
//   Result math runs on one shared 40-step restoring divider, used three
//   times (average, millivolt scaling, velocity quotient), then a 20-step
//   square root.
//   rsp_* holds pressure_diff and flow_velocity in one item. The output
//   register lets a new window fill while a result waits; if the next window
//   closes before rsp_tready, the block holds its result and stays not ready.
//   csr_* writes sample_count, supply_millivolts and density_milli; write only
//   while idle. Reset clears the accumulator, restores register defaults and
//   empties the output register.
// ----------------------------------------------------------------------------
module averaged_pitot_pressure_velocity_unit
   import apv_pkg::*;
#(
   parameter int MAX_SAMPLES = 256,
   parameter int ADC_BITS    = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((ADC_BITS + 7) / 8) * 8 - 1:0] req_tdata,   // adc_sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [RSP_W-1:0]                      rsp_tdata,   // pressure_diff, flow_velocity
   input  logic                                  csr_we,
   input  logic [CSR_INDEX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = ADC_BITS + CNT_W;
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int PROD_W = SUPPLY_W + ADC_BITS;
   localparam int DP_W   = PROD_W + 1;
   localparam logic signed [DP_W-1:0] DP_HI = DP_W'(PD_MAX);
   localparam logic signed [DP_W-1:0] DP_LO = DP_W'(PD_MIN);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_AVG,
      S_DIV_MV,
      S_VEL_SETUP,
      S_DIV_VEL,
      S_SQRT,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [SUPPLY_W-1:0]   supply_ff, supply_in;
   logic [DENSITY_W-1:0]  density_ff, density_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [PD_W-1:0] dp_ff, dp_in;
   logic [VEL_W-1:0]      vel_ff, vel_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]      rsp_tdata_ff, rsp_tdata_in;
   div_req_type           div_req_ff, div_req_in;
   sq_req_type            sq_req_ff, sq_req_in;
   div_rsp_type           div_rsp;
   sq_rsp_type            sq_rsp;

   logic [CMP_W-1:0]       window;
   logic [SUM_W-1:0]       sum_next;
   logic [CNT_W-1:0]       cnt_next;
   logic [ADC_BITS-1:0]    avg;
   logic [PROD_W-1:0]      product;
   logic [PROD_W-1:0]      mv;
   logic signed [DP_W-1:0] dp_full;
   logic [MAG_W-1:0]       mag;
   logic [MAG_SCALED_W-1:0] mag_scaled;
   logic [DENSITY_W-1:0]   dens;
   logic [VEL_W-1:0]       vel_mag;
   logic                   req_fire;

   apv_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   apv_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req_ff),
      .sq_rsp (sq_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      // clamp the window to one through MAX_SAMPLES
      if (count_ff == '0) begin
         window = CMP_W'(1);
      end else if (CMP_W'(count_ff) > CMP_W'(MAX_SAMPLES)) begin
         window = CMP_W'(MAX_SAMPLES);
      end else begin
         window = CMP_W'(count_ff);
      end
      sum_next   = sum_ff + SUM_W'(req_tdata[ADC_BITS-1:0]);
      cnt_next   = cnt_ff + 1'b1;
      avg        = div_rsp.quotient[ADC_BITS-1:0];
      product    = PROD_W'(supply_ff) * PROD_W'(avg);
      mv         = div_rsp.quotient[PROD_W-1:0];
      dp_full    = signed'(DP_W'(mv) - DP_W'(supply_ff >> 1));
      mag        = dp_ff[PD_W-1] ? MAG_W'(-dp_ff) : MAG_W'(dp_ff);
      mag_scaled = MAG_SCALED_W'(mag) * MAG_SCALED_W'(VEL_SCALE);
      dens       = (density_ff == '0) ? DENSITY_W'(1) : density_ff;
      vel_mag    = sq_rsp.root[SQ_ROOT_W-1] ? VEL_MAX : VEL_W'(sq_rsp.root);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      supply_in     = supply_ff;
      density_in    = density_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      dp_in         = dp_ff;
      vel_in        = vel_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      div_req_in    = div_req_ff;
      div_req_in.start = 1'b0;
      sq_req_in     = sq_req_ff;
      sq_req_in.start  = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: count_in   = csr_wdata[COUNT_W-1:0];
            CSR_SUPPLY_MV:    supply_in  = csr_wdata[SUPPLY_W-1:0];
            CSR_DENSITY:      density_in = csr_wdata[DENSITY_W-1:0];
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (CMP_W'(cnt_next) >= window) begin
                  div_req_in.start = 1'b1;
                  div_req_in.num   = DIV_NUM_W'(sum_next);
                  div_req_in.den   = DIV_DEN_W'(cnt_next);
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIV_AVG;
               end else begin
                  sum_in = sum_next;
                  cnt_in = cnt_next;
               end
            end
         end
         S_DIV_AVG: begin
            if (div_rsp.done) begin
               div_req_in.start = 1'b1;
               div_req_in.num   = DIV_NUM_W'(product);
               div_req_in.den   = DIV_DEN_W'(ADC_FULL_SCALE);
               state_in = S_DIV_MV;
            end
         end
         S_DIV_MV: begin
            if (div_rsp.done) begin
               // saturate the pressure before it feeds the velocity
               if (dp_full > DP_HI) begin
                  dp_in = PD_W'(PD_MAX);
               end else if (dp_full < DP_LO) begin
                  dp_in = PD_W'(PD_MIN);
               end else begin
                  dp_in = dp_full[PD_W-1:0];
               end
               state_in = S_VEL_SETUP;
            end
         end
         S_VEL_SETUP: begin
            div_req_in.start = 1'b1;
            div_req_in.num   = DIV_NUM_W'({mag_scaled, {VEL_SHIFT{1'b0}}});
            div_req_in.den   = dens;
            state_in = S_DIV_VEL;
         end
         S_DIV_VEL: begin
            if (div_rsp.done) begin
               sq_req_in.start    = 1'b1;
               sq_req_in.radicand = SQ_RAD_W'(div_rsp.quotient);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_rsp.done) begin
               vel_in   = dp_ff[PD_W-1] ? VEL_W'(-vel_mag) : vel_mag;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register frees up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_W'({vel_ff, dp_ff});
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         count_ff         <= SAMPLE_COUNT_RESET;
         supply_ff        <= SUPPLY_MV_RESET;
         density_ff       <= DENSITY_RESET;
         sum_ff           <= '0;
         cnt_ff           <= '0;
         rsp_tvalid_ff    <= 1'b0;
         div_req_ff.start <= 1'b0;
         sq_req_ff.start  <= 1'b0;
      end else begin
         state_ff         <= state_in;
         count_ff         <= count_in;
         supply_ff        <= supply_in;
         density_ff       <= density_in;
         sum_ff           <= sum_in;
         cnt_ff           <= cnt_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         div_req_ff.start <= div_req_in.start;
         sq_req_ff.start  <= sq_req_in.start;
      end
      dp_ff              <= dp_in;
      vel_ff             <= vel_in;
      rsp_tdata_ff       <= rsp_tdata_in;
      div_req_ff.num     <= div_req_in.num;
      div_req_ff.den     <= div_req_in.den;
      sq_req_ff.radicand <= sq_req_in.radicand;
   end

   // divider results arrive only while a division is awaited
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_AVG || state_ff == S_DIV_MV ||
                        state_ff == S_DIV_VEL))
      else $error("divider done outside a division state");

   assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> (state_ff == S_SQRT))
      else $error("square root done outside its state");

   // a stalled result keeps the finished item parked in the emit state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_EMIT))
      else $error("result overwritten while output stalled");

   assert property (@(posedge clock) disable iff (reset)
      div_req_ff.start |-> !req_tready)
      else $error("division started while accepting items");

endmodule
